@@ rtl/core/bvc_pkg.sv @@
// ----------------------------------------------------------------------------
// Bounding volume cull package
// Operation and verdict codes, register indexes and the control word that
// travels down the classifier pipeline beside the arithmetic.
// ----------------------------------------------------------------------------
package bvc_pkg;

  // Default coordinate width: signed Q15.8.
  localparam int unsigned CoordBitsDef = 24;

  // Width of the configuration register index.
  localparam int unsigned CfgIdxBits = 3;

  typedef enum logic [1:0] {
    OP_BOUND    = 2'd0,
    OP_SPHERE   = 2'd1,
    OP_PART_BOX = 2'd2,
    OP_PART_SPH = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    VERDICT_REJECT = 2'd0,
    VERDICT_ACCEPT = 2'd1,
    VERDICT_SPLIT  = 2'd2
  } verdict_e;

  localparam logic [CfgIdxBits-1:0] RegQueryCenterX = 3'd0;
  localparam logic [CfgIdxBits-1:0] RegQueryCenterY = 3'd1;
  localparam logic [CfgIdxBits-1:0] RegQueryCenterZ = 3'd2;
  localparam logic [CfgIdxBits-1:0] RegQueryRadius  = 3'd3;
  localparam logic [CfgIdxBits-1:0] RegQueryHalfX   = 3'd4;
  localparam logic [CfgIdxBits-1:0] RegQueryHalfY   = 3'd5;
  localparam logic [CfgIdxBits-1:0] RegQueryHalfZ   = 3'd6;

  typedef struct packed {
    op_e  op;
    logic en;
  } ctrl_t;

endpackage

@@ rtl/core/bvc_diff.sv @@
// ----------------------------------------------------------------------------
// Cull classifier stage 1: centre differences
// Forms the per-axis distance magnitudes, the radius sum and the radius
// difference, and registers them with the item's control word.
// ----------------------------------------------------------------------------
module bvc_diff #(
  parameter int unsigned CoordBits = bvc_pkg::CoordBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  output logic                            ready_o,
  input  bvc_pkg::ctrl_t                  ctrl_i,
  input  logic [2:0][CoordBits-1:0]       center_i,
  input  logic [CoordBits-2:0]            radius_i,
  input  logic [2:0][CoordBits-2:0]       half_i,
  input  logic [2:0][CoordBits-1:0]       q_center_i,
  input  logic [CoordBits-2:0]            q_radius_i,
  output logic                            valid_o,
  input  logic                            ready_i,
  output bvc_pkg::ctrl_t                  ctrl_o,
  output logic [2:0][CoordBits-1:0]       ad_o,
  output logic [CoordBits-2:0]            rt_o,
  output logic [2:0][CoordBits-2:0]       th_o,
  output logic [CoordBits-1:0]            sum_o,
  output logic                            rdif_pos_o,
  output logic [CoordBits-2:0]            rdif_mag_o
);
  import bvc_pkg::*;

  logic                      valid_q;
  ctrl_t                     ctrl_q;
  logic [2:0][CoordBits-1:0] ad_d, ad_q;
  logic [CoordBits-2:0]      rt_q;
  logic [2:0][CoordBits-2:0] th_q;
  logic [CoordBits-1:0]      sum_d, sum_q;
  logic                      rdif_pos_d, rdif_pos_q;
  logic [CoordBits-2:0]      rdif_mag_d, rdif_mag_q;
  logic [2:0][CoordBits:0]   diff;
  logic [2:0][CoordBits:0]   diff_neg;

  // The difference of two signed values is one bit wider; its magnitude
  // never reaches 2^CoordBits, so it fits back into CoordBits bits.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      diff[a]     = {q_center_i[a][CoordBits-1], q_center_i[a]}
                  - {center_i[a][CoordBits-1], center_i[a]};
      diff_neg[a] = -diff[a];
      ad_d[a]     = diff[a][CoordBits] ? diff_neg[a][CoordBits-1:0]
                                       : diff[a][CoordBits-1:0];
    end
    sum_d      = {1'b0, q_radius_i} + {1'b0, radius_i};
    rdif_pos_d = q_radius_i > radius_i;
    rdif_mag_d = q_radius_i - radius_i;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      ctrl_q     <= ctrl_i;
      ad_q       <= ad_d;
      rt_q       <= radius_i;
      th_q       <= half_i;
      sum_q      <= sum_d;
      rdif_pos_q <= rdif_pos_d;
      rdif_mag_q <= rdif_mag_d;
    end
  end

  assign valid_o    = valid_q;
  assign ctrl_o     = ctrl_q;
  assign ad_o       = ad_q;
  assign rt_o       = rt_q;
  assign th_o       = th_q;
  assign sum_o      = sum_q;
  assign rdif_pos_o = rdif_pos_q;
  assign rdif_mag_o = rdif_mag_q;

endmodule

@@ rtl/core/bvc_square.sv @@
// ----------------------------------------------------------------------------
// Cull classifier stage 2: squares and box tests
// Squares the axis distances and both radius terms at full width, and runs
// the per-axis half box comparisons.
// ----------------------------------------------------------------------------
module bvc_square #(
  parameter int unsigned CoordBits = bvc_pkg::CoordBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  output logic                            ready_o,
  input  bvc_pkg::ctrl_t                  ctrl_i,
  input  logic [2:0][CoordBits-1:0]       ad_i,
  input  logic [CoordBits-2:0]            rt_i,
  input  logic [2:0][CoordBits-2:0]       th_i,
  input  logic [CoordBits-1:0]            sum_i,
  input  logic                            rdif_pos_i,
  input  logic [CoordBits-2:0]            rdif_mag_i,
  input  logic [2:0][CoordBits-2:0]       q_half_i,
  output logic                            valid_o,
  input  logic                            ready_i,
  output bvc_pkg::ctrl_t                  ctrl_o,
  output logic [2:0][2*CoordBits-1:0]     sq_o,
  output logic [2*CoordBits-1:0]          sum2_o,
  output logic                            rdif_pos_o,
  output logic [2*CoordBits-3:0]          rdif2_o,
  output logic                            box_in_o,
  output logic                            part_box_o
);
  import bvc_pkg::*;

  logic                          valid_q;
  ctrl_t                         ctrl_q;
  logic [2:0][2*CoordBits-1:0]   sq_d, sq_q;
  logic [2*CoordBits-1:0]        sum2_d, sum2_q;
  logic                          rdif_pos_q;
  logic [2*CoordBits-3:0]        rdif2_d, rdif2_q;
  logic                          box_in_d, box_in_q;
  logic                          part_box_d, part_box_q;
  logic [2:0][CoordBits:0]       reach;
  logic [2:0][CoordBits-1:0]     limit;

  always_comb begin
    box_in_d   = 1'b1;
    part_box_d = 1'b1;
    for (int a = 0; a < 3; a++) begin
      sq_d[a]  = ad_i[a] * ad_i[a];
      // Test box fully inside the query box along this axis.
      reach[a] = {1'b0, ad_i[a]} + {2'b00, th_i[a]};
      if (reach[a] >= {2'b00, q_half_i[a]}) begin
        box_in_d = 1'b0;
      end
      // Part sphere: distance minus radius below the query half extent.
      limit[a] = {1'b0, q_half_i[a]} + {1'b0, rt_i};
      if (ad_i[a] >= limit[a]) begin
        part_box_d = 1'b0;
      end
    end
    sum2_d  = sum_i * sum_i;
    rdif2_d = rdif_mag_i * rdif_mag_i;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      ctrl_q     <= ctrl_i;
      sq_q       <= sq_d;
      sum2_q     <= sum2_d;
      rdif_pos_q <= rdif_pos_i;
      rdif2_q    <= rdif2_d;
      box_in_q   <= box_in_d;
      part_box_q <= part_box_d;
    end
  end

  assign valid_o    = valid_q;
  assign ctrl_o     = ctrl_q;
  assign sq_o       = sq_q;
  assign sum2_o     = sum2_q;
  assign rdif_pos_o = rdif_pos_q;
  assign rdif2_o    = rdif2_q;
  assign box_in_o   = box_in_q;
  assign part_box_o = part_box_q;

endmodule

@@ rtl/core/bvc_decide.sv @@
// ----------------------------------------------------------------------------
// Cull classifier stages 3 and 4: distance sum and verdict
// Adds the three squared distances, then compares the result with the
// radius terms and drives the result register.
// ----------------------------------------------------------------------------
module bvc_decide #(
  parameter int unsigned CoordBits = bvc_pkg::CoordBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  output logic                            ready_o,
  input  bvc_pkg::ctrl_t                  ctrl_i,
  input  logic [2:0][2*CoordBits-1:0]     sq_i,
  input  logic [2*CoordBits-1:0]          sum2_i,
  input  logic                            rdif_pos_i,
  input  logic [2*CoordBits-3:0]          rdif2_i,
  input  logic                            box_in_i,
  input  logic                            part_box_i,
  output logic                            valid_o,
  input  logic                            ready_i,
  output bvc_pkg::verdict_e               verdict_o,
  output logic                            part_keep_o
);
  import bvc_pkg::*;

  localparam int unsigned D2Bits = 2 * CoordBits + 2;

  // Stage 3 registers.
  logic                   s3_valid_q;
  logic                   s3_ready;
  ctrl_t                  s3_ctrl_q;
  logic [D2Bits-1:0]      d2_d, d2_q;
  logic [2*CoordBits-1:0] s3_sum2_q;
  logic                   s3_rdif_pos_q;
  logic [2*CoordBits-3:0] s3_rdif2_q;
  logic                   s3_box_in_q;
  logic                   s3_part_box_q;

  // Stage 4 (result) registers.
  logic                   out_valid_q;
  verdict_e               verdict_d, verdict_q;
  logic                   keep_d, keep_q;
  logic                   far, inner, overlap;

  assign d2_d = {2'b00, sq_i[0]} + {2'b00, sq_i[1]} + {2'b00, sq_i[2]};

  assign ready_o  = !s3_valid_q || s3_ready;
  assign s3_ready = !out_valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ready_o) begin
        s3_valid_q <= valid_i;
      end
      if (s3_ready) begin
        out_valid_q <= s3_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      s3_ctrl_q     <= ctrl_i;
      d2_q          <= d2_d;
      s3_sum2_q     <= sum2_i;
      s3_rdif_pos_q <= rdif_pos_i;
      s3_rdif2_q    <= rdif2_i;
      s3_box_in_q   <= box_in_i;
      s3_part_box_q <= part_box_i;
    end
  end

  always_comb begin
    far       = d2_q > {2'b00, s3_sum2_q};
    overlap   = d2_q < {2'b00, s3_sum2_q};
    inner     = s3_rdif_pos_q && (d2_q < {4'b0000, s3_rdif2_q});
    verdict_d = VERDICT_REJECT;
    keep_d    = 1'b0;
    case (s3_ctrl_q.op)
      OP_BOUND, OP_SPHERE: begin
        if (far) begin
          verdict_d = VERDICT_REJECT;
        end else if (inner) begin
          verdict_d = VERDICT_ACCEPT;
        end else if (s3_ctrl_q.op == OP_BOUND && s3_box_in_q) begin
          verdict_d = VERDICT_ACCEPT;
        end else begin
          verdict_d = VERDICT_SPLIT;
        end
      end
      OP_PART_BOX: begin
        keep_d = s3_ctrl_q.en && s3_part_box_q;
      end
      OP_PART_SPH: begin
        keep_d = s3_ctrl_q.en && overlap;
      end
      default: begin
        keep_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (s3_valid_q && s3_ready) begin
      verdict_q <= verdict_d;
      keep_q    <= keep_d;
    end
  end

  assign valid_o     = out_valid_q;
  assign verdict_o   = verdict_q;
  assign part_keep_o = keep_q;

endmodule

@@ rtl/core/bounding_volume_cull_classifier.sv @@
// ----------------------------------------------------------------------------
// Bounding volume cull classifier
// Classifies test spheres, boxes and part spheres against a configured query
// sphere and half box in a four-stage pipeline.
// ----------------------------------------------------------------------------
// The classifier takes one item in every clock cycle while the output side
// is not stalled, and returns exactly one result item for each accepted
// item, in the order of acceptance. The four register stages are the centre
// difference stage, the multiplier stage that squares the axis distances and
// radius terms, the stage that adds the squared distances, and the result
// register that holds the verdict; each stage has its own valid bit and
// takes a new item whenever it is empty or its content moves on, so bubbles
// close up and a stall at the output fills the pipeline before input ready
// drops. The query volume is held in seven configuration registers written
// through the configuration port, which is always ready; the registers are
// read directly by the stages, so they should only be written while no item
// is in flight. Ops 0 and 1 give a verdict of reject, accept or split and
// leave part_keep low; ops 2 and 3 give part_keep and a reject verdict.
// ----------------------------------------------------------------------------
module bounding_volume_cull_classifier #(
  parameter int unsigned COORD_BITS = bvc_pkg::CoordBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write channel.
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bvc_pkg::CfgIdxBits-1:0] cfg_index_i,
  input  logic [COORD_BITS-1:0]          cfg_data_i,
  // Input item channel.
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     op_i,
  input  logic signed [COORD_BITS-1:0]   center_x_i,
  input  logic signed [COORD_BITS-1:0]   center_y_i,
  input  logic signed [COORD_BITS-1:0]   center_z_i,
  input  logic [COORD_BITS-2:0]          radius_i,
  input  logic [COORD_BITS-2:0]          half_x_i,
  input  logic [COORD_BITS-2:0]          half_y_i,
  input  logic [COORD_BITS-2:0]          half_z_i,
  input  logic                           part_enabled_i,
  // Result item channel.
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [1:0]                     verdict_o,
  output logic                           part_keep_o
);
  import bvc_pkg::*;

  // Query volume registers.
  logic [2:0][COORD_BITS-1:0] q_center_q;
  logic [COORD_BITS-2:0]      q_radius_q;
  logic [2:0][COORD_BITS-2:0] q_half_q;

  ctrl_t                      in_ctrl;
  logic [2:0][COORD_BITS-1:0] in_center;
  logic [2:0][COORD_BITS-2:0] in_half;

  // Stage 1 to stage 2.
  logic                       s1_valid, s1_ready;
  ctrl_t                      s1_ctrl;
  logic [2:0][COORD_BITS-1:0] s1_ad;
  logic [COORD_BITS-2:0]      s1_rt;
  logic [2:0][COORD_BITS-2:0] s1_th;
  logic [COORD_BITS-1:0]      s1_sum;
  logic                       s1_rdif_pos;
  logic [COORD_BITS-2:0]      s1_rdif_mag;

  // Stage 2 to stage 3.
  logic                         s2_valid, s2_ready;
  ctrl_t                        s2_ctrl;
  logic [2:0][2*COORD_BITS-1:0] s2_sq;
  logic [2*COORD_BITS-1:0]      s2_sum2;
  logic                         s2_rdif_pos;
  logic [2*COORD_BITS-3:0]      s2_rdif2;
  logic                         s2_box_in;
  logic                         s2_part_box;

  verdict_e                     verdict;

  // Configuration writes always complete; an index beyond the last
  // register is ignored. Radius and half extents take the low bits.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_center_q <= '0;
      q_radius_q <= '0;
      q_half_q   <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegQueryCenterX: q_center_q[0] <= cfg_data_i;
        RegQueryCenterY: q_center_q[1] <= cfg_data_i;
        RegQueryCenterZ: q_center_q[2] <= cfg_data_i;
        RegQueryRadius:  q_radius_q    <= cfg_data_i[COORD_BITS-2:0];
        RegQueryHalfX:   q_half_q[0]   <= cfg_data_i[COORD_BITS-2:0];
        RegQueryHalfY:   q_half_q[1]   <= cfg_data_i[COORD_BITS-2:0];
        RegQueryHalfZ:   q_half_q[2]   <= cfg_data_i[COORD_BITS-2:0];
        default: begin
        end
      endcase
    end
  end

  assign in_ctrl.op = op_e'(op_i);
  assign in_ctrl.en = part_enabled_i;
  assign in_center  = {center_z_i, center_y_i, center_x_i};
  assign in_half    = {half_z_i, half_y_i, half_x_i};

  bvc_diff #(
    .CoordBits (COORD_BITS)
  ) u_diff (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (in_valid_i),
    .ready_o    (in_ready_o),
    .ctrl_i     (in_ctrl),
    .center_i   (in_center),
    .radius_i   (radius_i),
    .half_i     (in_half),
    .q_center_i (q_center_q),
    .q_radius_i (q_radius_q),
    .valid_o    (s1_valid),
    .ready_i    (s1_ready),
    .ctrl_o     (s1_ctrl),
    .ad_o       (s1_ad),
    .rt_o       (s1_rt),
    .th_o       (s1_th),
    .sum_o      (s1_sum),
    .rdif_pos_o (s1_rdif_pos),
    .rdif_mag_o (s1_rdif_mag)
  );

  bvc_square #(
    .CoordBits (COORD_BITS)
  ) u_square (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (s1_valid),
    .ready_o    (s1_ready),
    .ctrl_i     (s1_ctrl),
    .ad_i       (s1_ad),
    .rt_i       (s1_rt),
    .th_i       (s1_th),
    .sum_i      (s1_sum),
    .rdif_pos_i (s1_rdif_pos),
    .rdif_mag_i (s1_rdif_mag),
    .q_half_i   (q_half_q),
    .valid_o    (s2_valid),
    .ready_i    (s2_ready),
    .ctrl_o     (s2_ctrl),
    .sq_o       (s2_sq),
    .sum2_o     (s2_sum2),
    .rdif_pos_o (s2_rdif_pos),
    .rdif2_o    (s2_rdif2),
    .box_in_o   (s2_box_in),
    .part_box_o (s2_part_box)
  );

  bvc_decide #(
    .CoordBits (COORD_BITS)
  ) u_decide (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s2_valid),
    .ready_o     (s2_ready),
    .ctrl_i      (s2_ctrl),
    .sq_i        (s2_sq),
    .sum2_i      (s2_sum2),
    .rdif_pos_i  (s2_rdif_pos),
    .rdif2_i     (s2_rdif2),
    .box_in_i    (s2_box_in),
    .part_box_i  (s2_part_box),
    .valid_o     (out_valid_o),
    .ready_i     (out_ready_i),
    .verdict_o   (verdict),
    .part_keep_o (part_keep_o)
  );

  assign verdict_o = verdict;

  // With the result register empty, every stage can move on, so the input
  // side must be ready.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled while the result register is empty");

  // A kept part comes only from a part test, whose verdict field is zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && part_keep_o) |-> (verdict_o == VERDICT_REJECT))
    else $error("part keep set together with a classification verdict");

  // An item accepted into an empty, never stalled pipeline passes the difference,
  // square, sum and result registers in turn and shows up as a valid result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && !s1_valid && !s2_valid && !out_valid_o
     && out_ready_i) ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i
    |=> out_valid_o)
    else $error("item lost in the pipeline");

endmodule

@@ test/bvc_cull_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bounding volume cull checker
// Watches the configuration, input and result channels of the classifier,
// keeps its own copy of the query volume, predicts each result from the
// accepted input item and compares it field by field with the result item.
// ----------------------------------------------------------------------------
module bvc_cull_checker #(
  parameter int unsigned COORD_BITS = bvc_pkg::CoordBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [bvc_pkg::CfgIdxBits-1:0] cfg_index_i,
  input  logic [COORD_BITS-1:0]          cfg_data_i,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  logic [1:0]                     op_i,
  input  logic signed [COORD_BITS-1:0]   center_x_i,
  input  logic signed [COORD_BITS-1:0]   center_y_i,
  input  logic signed [COORD_BITS-1:0]   center_z_i,
  input  logic [COORD_BITS-2:0]          radius_i,
  input  logic [COORD_BITS-2:0]          half_x_i,
  input  logic [COORD_BITS-2:0]          half_y_i,
  input  logic [COORD_BITS-2:0]          half_z_i,
  input  logic                           part_enabled_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  logic [1:0]                     verdict_i,
  input  logic                           part_keep_i,
  output int unsigned                    fail_count_o,
  output int unsigned                    pending_o
);
  import bvc_pkg::*;

  typedef struct packed {
    verdict_e verdict;
    logic     keep;
  } cull_result_t;

  // Query volume as the block should hold it.
  logic signed [COORD_BITS-1:0] q_center [3];
  logic [COORD_BITS-2:0]        q_radius;
  logic [COORD_BITS-2:0]        q_half [3];

  cull_result_t verdict_q [$];
  int unsigned  mismatches;

  function automatic cull_result_t classify_volume(
    input op_e                          op,
    input logic signed [COORD_BITS-1:0] cx,
    input logic signed [COORD_BITS-1:0] cy,
    input logic signed [COORD_BITS-1:0] cz,
    input logic [COORD_BITS-2:0]        rt,
    input logic [COORD_BITS-2:0]        hx,
    input logic [COORD_BITS-2:0]        hy,
    input logic [COORD_BITS-2:0]        hz,
    input logic                         en
  );
    longint       axis_dist [3];
    longint       tbox [3];
    longint       qbox [3];
    longint       d2;
    longint       rsum;
    longint       rdif;
    longint       rtest;
    logic         in_box;
    logic         hit;
    cull_result_t res;

    // Everything is widened to 64 bits, so no term can wrap.
    axis_dist[0] = longint'(q_center[0]) - longint'(cx);
    axis_dist[1] = longint'(q_center[1]) - longint'(cy);
    axis_dist[2] = longint'(q_center[2]) - longint'(cz);
    tbox[0] = longint'(hx);
    tbox[1] = longint'(hy);
    tbox[2] = longint'(hz);
    d2 = 0;
    for (int i = 0; i < 3; i++) begin
      if (axis_dist[i] < 0) axis_dist[i] = -axis_dist[i];
      qbox[i] = longint'(q_half[i]);
      d2 += axis_dist[i] * axis_dist[i];
    end
    rtest = longint'(rt);
    rsum  = rtest + longint'(q_radius);
    rdif  = longint'(q_radius) - rtest;

    res.verdict = VERDICT_REJECT;
    res.keep    = 1'b0;
    case (op)
      OP_BOUND, OP_SPHERE: begin
        in_box = (axis_dist[0] + tbox[0] < qbox[0]) &&
                 (axis_dist[1] + tbox[1] < qbox[1]) &&
                 (axis_dist[2] + tbox[2] < qbox[2]);
        if (d2 > rsum * rsum) begin
          res.verdict = VERDICT_REJECT;
        end else if (rdif > 0 && d2 < rdif * rdif) begin
          res.verdict = VERDICT_ACCEPT;
        end else if (op == OP_BOUND && in_box) begin
          res.verdict = VERDICT_ACCEPT;
        end else begin
          res.verdict = VERDICT_SPLIT;
        end
      end
      OP_PART_BOX: begin
        hit = 1'b1;
        for (int i = 0; i < 3; i++) begin
          if (axis_dist[i] - rtest >= qbox[i]) hit = 1'b0;
        end
        res.keep = en && hit;
      end
      default: begin
        res.keep = en && (d2 < rsum * rsum);
      end
    endcase
    return res;
  endfunction

  task automatic note_failure(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $time, msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    cull_result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        q_center[i] = '0;
        q_half[i]   = '0;
      end
      q_radius = '0;
      verdict_q.delete();
      mismatches   = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        // Unsigned registers drop the top bit of the data word.
        case (cfg_index_i)
          RegQueryCenterX: q_center[0] = cfg_data_i;
          RegQueryCenterY: q_center[1] = cfg_data_i;
          RegQueryCenterZ: q_center[2] = cfg_data_i;
          RegQueryRadius:  q_radius    = cfg_data_i[COORD_BITS-2:0];
          RegQueryHalfX:   q_half[0]   = cfg_data_i[COORD_BITS-2:0];
          RegQueryHalfY:   q_half[1]   = cfg_data_i[COORD_BITS-2:0];
          RegQueryHalfZ:   q_half[2]   = cfg_data_i[COORD_BITS-2:0];
          default: ;
        endcase
      end

      if (in_valid_i && in_ready_i) begin
        verdict_q.insert(verdict_q.size(),
                         classify_volume(op_e'(op_i), center_x_i, center_y_i, center_z_i,
                                         radius_i, half_x_i, half_y_i, half_z_i,
                                         part_enabled_i));
      end

      if (out_valid_i && out_ready_i) begin
        if (verdict_q.size() == 0) begin
          note_failure($sformatf("result item with none expected: verdict %0d keep %0d",
                                 verdict_i, part_keep_i));
        end else begin
          want = verdict_q.pop_front();
          if (verdict_i !== want.verdict)
            note_failure($sformatf("verdict mismatch: expected %0d, actual %0d",
                                   want.verdict, verdict_i));
          if (part_keep_i !== want.keep)
            note_failure($sformatf("part_keep mismatch: expected %0d, actual %0d",
                                   want.keep, part_keep_i));
        end
      end

      fail_count_o <= mismatches;
      pending_o    <= verdict_q.size();
    end
  end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bounding volume cull classifier testbench
// Drives directed and random items through the classifier under a series of
// query volumes, with random idling on both channels, a long output hold-off
// and a full drain mid-phase; a separate checker predicts every result.
// ----------------------------------------------------------------------------
module tb;
  import bvc_pkg::*;

  localparam int unsigned COORD_BITS = CoordBitsDef;

  // Extremes of the signed coordinates and the unsigned radii and extents.
  localparam logic [COORD_BITS-1:0] CoordMin = {1'b1, {(COORD_BITS - 1){1'b0}}};
  localparam logic [COORD_BITS-1:0] CoordMax = {1'b0, {(COORD_BITS - 1){1'b1}}};
  localparam logic [COORD_BITS-2:0] UMax     = '1;

  // The register index past the end of the list; writes to it are ignored.
  localparam logic [CfgIdxBits-1:0] RegUnused = 3'd7;

  localparam int RandPerPhase = 255;
  localparam int NumPhases    = 6;
  // Length of the deliberate output hold-off, in cycles.
  localparam int LongHold     = 200;
  // Cycles without any accepted item before the run is declared hung.
  localparam int StallLimit   = 2000;
  // Cycles left after the drain for stray result items to show up.
  localparam int TailCycles   = 16;

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [CfgIdxBits-1:0]        cfg_index;
  logic [COORD_BITS-1:0]        cfg_data;
  logic                         in_valid;
  logic                         in_ready;
  logic [1:0]                   item_op;
  logic signed [COORD_BITS-1:0] center_x;
  logic signed [COORD_BITS-1:0] center_y;
  logic signed [COORD_BITS-1:0] center_z;
  logic [COORD_BITS-2:0]        radius;
  logic [COORD_BITS-2:0]        half_x;
  logic [COORD_BITS-2:0]        half_y;
  logic [COORD_BITS-2:0]        half_z;
  logic                         part_enabled;
  logic                         out_valid;
  logic                         out_ready;
  logic [1:0]                   verdict;
  logic                         part_keep;

  int unsigned fail_count;
  int unsigned pending;

  // Idling switches for the two sides, and the hold-off request counter.
  // The receiver compares hold_seq with its own copy, so a bump of the
  // counter asks for exactly one long hold-off.
  logic tx_idle_en = 1'b0;
  logic rx_idle_en = 1'b0;
  int   hold_seq   = 0;
  int   stall_cycles = 0;

  // The query volume currently programmed, used to aim the random items.
  logic signed [COORD_BITS-1:0] query_cx;
  logic signed [COORD_BITS-1:0] query_cy;
  logic signed [COORD_BITS-1:0] query_cz;
  logic [COORD_BITS-2:0]        query_r;
  logic [COORD_BITS-2:0]        query_hx;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  bounding_volume_cull_classifier #(
    .COORD_BITS (COORD_BITS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .op_i           (item_op),
    .center_x_i     (center_x),
    .center_y_i     (center_y),
    .center_z_i     (center_z),
    .radius_i       (radius),
    .half_x_i       (half_x),
    .half_y_i       (half_y),
    .half_z_i       (half_z),
    .part_enabled_i (part_enabled),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .verdict_o      (verdict),
    .part_keep_o    (part_keep)
  );

  bvc_cull_checker #(
    .COORD_BITS (COORD_BITS)
  ) cull_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .op_i           (item_op),
    .center_x_i     (center_x),
    .center_y_i     (center_y),
    .center_z_i     (center_z),
    .radius_i       (radius),
    .half_x_i       (half_x),
    .half_y_i       (half_y),
    .half_z_i       (half_z),
    .part_enabled_i (part_enabled),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .verdict_i      (verdict),
    .part_keep_i    (part_keep),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // Watchdog. Any accepted item on any channel restarts the count, so only
  // a genuine hang (lost result, ready stuck low) can reach the limit.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= StallLimit) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Result side. Each pass of the loop starts at a clock edge and makes a
  // single assignment to out_ready, so the level never bounces within a
  // step. A hold-off request takes priority over the random idle bursts.
  initial begin : receiver
    int hold_seen;
    hold_seen = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        out_ready <= 1'b0;
        repeat (LongHold - 1) @(posedge clk_i);
      end else if (rx_idle_en && ($urandom_range(0, 9) == 0)) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(0, 14)) @(posedge clk_i);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic logic [COORD_BITS-2:0] rand_mag(input int s);
    int sc;
    sc = (s > COORD_BITS - 1) ? COORD_BITS - 1 : ((s < 0) ? 0 : s);
    return (COORD_BITS - 1)'($urandom & ((32'd1 << sc) - 1));
  endfunction

  // A coordinate within roughly 2^s of base, either side; wraps at the ends.
  function automatic logic [COORD_BITS-1:0] near_coord(input logic [COORD_BITS-1:0] base,
                                                       input int s);
    logic [COORD_BITS-1:0] off;
    int                    sc;
    sc  = (s > COORD_BITS) ? COORD_BITS : ((s < 0) ? 0 : s);
    off = COORD_BITS'($urandom & ((sc >= 32) ? 32'hffff_ffff : ((32'd1 << sc) - 1)));
    return ($urandom_range(0, 1) != 0) ? base - off : base + off;
  endfunction

  // Offers one configuration write and waits for it to be taken. The
  // caller lowers cfg_valid after its last write.
  task automatic write_reg(input logic [CfgIdxBits-1:0] idx, input logic [COORD_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
  endtask

  // Programs the whole query volume. The unsigned registers get a random
  // stray top bit, which the block has to drop. Only called while idle.
  task automatic set_query(input logic [COORD_BITS-1:0] cx, input logic [COORD_BITS-1:0] cy,
                           input logic [COORD_BITS-1:0] cz, input logic [COORD_BITS-2:0] r,
                           input logic [COORD_BITS-2:0] hx, input logic [COORD_BITS-2:0] hy,
                           input logic [COORD_BITS-2:0] hz, input logic poke_unused);
    logic stray;
    query_cx = cx;
    query_cy = cy;
    query_cz = cz;
    query_r  = r;
    query_hx = hx;
    write_reg(RegQueryCenterX, cx);
    write_reg(RegQueryCenterY, cy);
    write_reg(RegQueryCenterZ, cz);
    stray = 1'($urandom_range(0, 1));
    write_reg(RegQueryRadius, {stray, r});
    stray = 1'($urandom_range(0, 1));
    write_reg(RegQueryHalfX, {stray, hx});
    stray = 1'($urandom_range(0, 1));
    write_reg(RegQueryHalfY, {stray, hy});
    stray = 1'($urandom_range(0, 1));
    write_reg(RegQueryHalfZ, {stray, hz});
    // A write past the end of the register list must leave everything alone.
    if (poke_unused) write_reg(RegUnused, COORD_BITS'($urandom));
    cfg_valid <= 1'b0;
  endtask

  task automatic random_query(input int s, input logic poke_unused);
    set_query(COORD_BITS'($urandom), COORD_BITS'($urandom), COORD_BITS'($urandom),
              rand_mag(s), rand_mag(s), rand_mag(s), rand_mag(s), poke_unused);
  endtask

  // Offers one item, after an optional idle burst, and returns at the edge
  // where it is accepted. valid is left high so that the next item can
  // follow straight on without a bubble.
  task automatic push_item(input op_e op, input logic [COORD_BITS-1:0] cx,
                           input logic [COORD_BITS-1:0] cy, input logic [COORD_BITS-1:0] cz,
                           input logic [COORD_BITS-2:0] r, input logic [COORD_BITS-2:0] hx,
                           input logic [COORD_BITS-2:0] hy, input logic [COORD_BITS-2:0] hz,
                           input logic en);
    if (tx_idle_en && ($urandom_range(0, 7) == 0)) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_valid     <= 1'b1;
    item_op      <= op;
    center_x     <= cx;
    center_y     <= cy;
    center_z     <= cz;
    radius       <= r;
    half_x       <= hx;
    half_y       <= hy;
    half_z       <= hz;
    part_enabled <= en;
    do @(posedge clk_i); while (!in_ready);
  endtask

  // Waits until the checker has nothing outstanding. The count it reports
  // is registered, so the task always lets the clock tick before it looks.
  task automatic wait_drained();
    do @(posedge clk_i); while (pending != 0);
  endtask

  // One random item aimed at the current query volume. Most items sit at
  // the query's own scale so that all verdicts turn up; some are placed
  // exactly on the sphere or box boundary, and a tenth are pure noise
  // across the full range of every field.
  task automatic offer_random_volume(input int s);
    int                    mode;
    op_e                   op;
    logic                  en;
    logic [COORD_BITS-1:0] cx;
    logic [COORD_BITS-1:0] cy;
    logic [COORD_BITS-1:0] cz;
    logic [COORD_BITS-2:0] r;
    logic [COORD_BITS-2:0] hx;
    logic [COORD_BITS-2:0] hy;
    logic [COORD_BITS-2:0] hz;
    mode = $urandom_range(0, 9);
    op   = op_e'($urandom_range(0, 3));
    en   = ($urandom_range(0, 4) != 0);
    r    = rand_mag(s + $urandom_range(0, 2) - 1);
    hx   = rand_mag(s);
    hy   = rand_mag(s);
    hz   = rand_mag(s);
    cx   = near_coord(query_cx, s + 1);
    cy   = near_coord(query_cy, s + 1);
    cz   = near_coord(query_cz, s + 1);
    case (mode)
      0: begin
        cx = COORD_BITS'($urandom);
        cy = COORD_BITS'($urandom);
        cz = COORD_BITS'($urandom);
        r  = (COORD_BITS - 1)'($urandom);
        hx = (COORD_BITS - 1)'($urandom);
        hy = (COORD_BITS - 1)'($urandom);
        hz = (COORD_BITS - 1)'($urandom);
        en = 1'($urandom_range(0, 1));
      end
      1: begin
        // Spheres just touching along x.
        cx = query_cx + r + query_r;
        cy = query_cy;
        cz = query_cz;
      end
      2: begin
        // Part sphere edge exactly on the query box face along x.
        cx = query_cx - r - query_hx;
        cy = query_cy;
        cz = query_cz;
      end
      default: ;
    endcase
    push_item(op, cx, cy, cz, r, hx, hy, hz, en);
  endtask

  initial begin : stimulus
    int scale;
    rst_ni       <= 1'b0;
    cfg_valid    <= 1'b0;
    cfg_index    <= RegQueryCenterX;
    cfg_data     <= '0;
    in_valid     <= 1'b0;
    item_op      <= OP_BOUND;
    center_x     <= '0;
    center_y     <= '0;
    center_z     <= '0;
    radius       <= '0;
    half_x       <= '0;
    half_y       <= '0;
    half_z       <= '0;
    part_enabled <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // With the registers still at their reset value of zero, a point test
    // at the origin only touches the query sphere: a split for the bound
    // test and no keep for the part-sphere overlap, whose test is strict.
    push_item(OP_BOUND, 0, 0, 0, 0, 0, 0, 0, 1'b1);
    push_item(OP_PART_SPH, 0, 0, 0, 0, 0, 0, 0, 1'b1);
    in_valid <= 1'b0;
    wait_drained();

    // Directed part: query sphere of radius 16.0 and half box of 8.0 at the
    // origin, with a write past the end of the register list.
    set_query(0, 0, 0, 'h1000, 'h800, 'h800, 'h800, 1'b1);
    tx_idle_en <= 1'b1;
    rx_idle_en <= 1'b1;
    // Bound test: far away, deep inside the sphere, held by the box alone,
    // straddling, and exactly touching (equality is not a reject).
    push_item(OP_BOUND, 'h100000, 0, 0, 'h100, 'h100, 'h100, 'h100, 1'b1);
    push_item(OP_BOUND, 'h100, 0, 0, 'h100, 'h100, 'h100, 'h100, 1'b0);
    push_item(OP_BOUND, 0, 0, 0, 'h2000, 'h100, 'h100, 'h100, 1'b1);
    push_item(OP_BOUND, 'hF00, 0, 0, 'h200, 'h200, 'h200, 'h200, 1'b1);
    push_item(OP_BOUND, 'h1100, 0, 0, 'h100, 0, 0, 0, 1'b0);
    // Sphere test: the box case now splits, equal radii split, plus the
    // plain accept and reject.
    push_item(OP_SPHERE, 0, 0, 0, 'h2000, 'h100, 'h100, 'h100, 1'b1);
    push_item(OP_SPHERE, 0, -COORD_BITS'('h100), 0, 'h100, 0, 0, 0, 1'b1);
    push_item(OP_SPHERE, 0, 0, -COORD_BITS'('h200000), 'h100, 0, 0, 0, 1'b0);
    push_item(OP_SPHERE, 0, 0, 0, 'h1000, 0, 0, 0, 1'b1);
    // Part versus box: inside, exactly on the face, disabled, and a part
    // whose radius exceeds its distance along each axis.
    push_item(OP_PART_BOX, 'h900, 0, 0, 'h200, 'h7FFF, 0, 0, 1'b1);
    push_item(OP_PART_BOX, 'hA00, 0, 0, 'h200, 0, 0, 0, 1'b1);
    push_item(OP_PART_BOX, 'h900, 0, 0, 'h200, 0, 0, 0, 1'b0);
    push_item(OP_PART_BOX, -COORD_BITS'('h3000), 'h3000, -COORD_BITS'('h3000), 'h4000,
              0, 0, 0, 1'b1);
    // Part versus sphere: overlapping, touching, and disabled.
    push_item(OP_PART_SPH, 0, 'h1000, 0, 'h100, 0, 0, 0, 1'b1);
    push_item(OP_PART_SPH, 0, 0, 'h1100, 'h100, 0, 0, 0, 1'b1);
    push_item(OP_PART_SPH, 0, 0, 0, 'h100, 0, 0, 0, 1'b0);
    // Field extremes.
    push_item(OP_BOUND, CoordMin, CoordMin, CoordMin, UMax, UMax, UMax, UMax, 1'b1);
    push_item(OP_BOUND, CoordMax, CoordMax, CoordMax, 0, 0, 0, 0, 1'b1);
    push_item(OP_BOUND, 0, 0, 0, 'h2000, UMax, UMax, UMax, 1'b0);
    push_item(OP_SPHERE, 0, 0, 0, UMax, 0, 0, 0, 1'b1);
    push_item(OP_PART_BOX, CoordMin, CoordMin, CoordMin, UMax, UMax, UMax, UMax, 1'b1);
    push_item(OP_PART_SPH, CoordMax, CoordMax, CoordMax, UMax, UMax, UMax, UMax, 1'b1);
    in_valid <= 1'b0;
    wait_drained();

    // Random phases, each under its own query volume: random, the most
    // negative centre with every size at its maximum, the most positive
    // centre with a zero radius and a degenerate box, then more random
    // volumes. The last phase runs without any idling.
    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: begin
          scale = $urandom_range(6, 14);
          random_query(scale, 1'b0);
        end
        1: begin
          scale = COORD_BITS - 2;
          set_query(CoordMin, CoordMin, CoordMin, UMax, UMax, UMax, UMax, 1'b1);
        end
        2: begin
          scale = 8;
          set_query(CoordMax, CoordMax, CoordMax, 0, 0, 0, 0, 1'b0);
        end
        3: begin
          scale = $urandom_range(4, 18);
          random_query(scale, 1'($urandom_range(0, 1)));
        end
        4: begin
          scale = COORD_BITS - 4;
          random_query(scale, 1'b0);
        end
        default: begin
          scale = 12;
          random_query(scale, 1'b1);
        end
      endcase
      tx_idle_en <= (ph != NumPhases - 1);
      rx_idle_en <= (ph != NumPhases - 1);
      for (int n = 0; n < RandPerPhase; n++) begin
        // Long output hold-off while items keep coming, so the pipeline
        // fills up and input ready has to drop.
        if (ph == 0 && n == 60) hold_seq <= hold_seq + 1;
        // Sender pause until every outstanding result has come back.
        if (ph == 3 && n == 120) begin
          in_valid <= 1'b0;
          wait_drained();
        end
        offer_random_volume(scale);
      end
      in_valid <= 1'b0;
      wait_drained();
    end

    // Give any stray result items a chance to appear before the verdict.
    repeat (TailCycles) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
